### hdl/lat_pkg.sv
package lat_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = COL_W + ROW_W;
    localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
    localparam int DIM_W      = 7;
    localparam int ENTRY_W    = 5;
    localparam int COUNT_W    = 4;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int STEP_W     = 4;

    localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(8);
    localparam logic [ENTRY_W-1:0] ALIVE_BIT = ENTRY_W'(8'h01);
    localparam logic [ENTRY_W-1:0] COUNT_ONE = ENTRY_W'(8'h02);
    localparam logic [COUNT_W-1:0] COUNT_SURVIVE = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] COUNT_BIRTH   = COUNT_W'(3);
    localparam logic [DIM_W-1:0]   DIM_MIN = DIM_W'(3);

    localparam logic [MODE_W-1:0] MODE_SET_ALIVE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SET_DEAD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_GENERATE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_CHECK_RD,
        ST_CHECK,
        ST_PUT_RD,
        ST_PUT_WR,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_OUT
    } lat_state_t;

    typedef struct packed {
        logic load_item;
        logic use_step;
        logic cell_wr_put;
        logic cell_wr_clear;
        logic snap_wr;
        logic res_from_now;
        logic res_from_tgt;
        logic tgt_from_scan;
        logic step_clr;
        logic step_inc;
        logic advance;
        logic clear_advance;
        logic pos_clr;
        logic out_load;
    } lat_cmd_t;

    typedef struct packed {
        logic now_alive;
        logic tgt_alive;
        logic mode_read;
        logic mode_gen;
        logic coord_err;
        logic step_last;
        logic scan_last;
        logic clear_last;
        logic gen_change;
        logic out_busy;
    } lat_stat_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v < DIM_MIN)
            r = DIM_MIN;
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

endpackage

### hdl/lat_if.sv
interface lat_in_if;
    logic                       valid;
    logic                       ready;
    logic [lat_pkg::MODE_W-1:0] mode;
    logic [lat_pkg::COL_W-1:0]  column;
    logic [lat_pkg::ROW_W-1:0]  row;

    modport source (output valid, mode, column, row, input ready);
    modport sink   (input valid, mode, column, row, output ready);
endinterface

interface lat_out_if;
    logic                       valid;
    logic                       ready;
    logic                       cell_alive;
    logic                       coord_error;
    logic [lat_pkg::MODE_W-1:0] done_mode;

    modport source (output valid, cell_alive, coord_error, done_mode, input ready);
    modport sink   (input valid, cell_alive, coord_error, done_mode, output ready);
endinterface

### hdl/life_automaton_torus_engine_top.sv
// channel   dir   payload                              accepted when
// in_ch     in    mode, column, row                    valid && ready
// out_ch    out   cell_alive, coord_error, done_mode   valid && ready
// cfg       in    cfg_index, cfg_data                  cfg_we
//
// Read or set outside the grid: DECODE, OUT. Read or no-op set: CHECK_RD, CHECK, OUT.
// Set that changes a cell: CHECK, then nine read-modify-write steps on the cell RAM.
// Generation: copy pass, then scan pass, nine steps per changed cell; single-port RAMs.
// After reset a clearing pass writes all 4096 cells with in_ch.ready low.
// A result waits in the output register; the next item is taken meanwhile.
module life_automaton_torus_engine_top (
    input  logic                          clk,
    input  logic                          rst_n,
    lat_in_if.sink                        in_ch,
    lat_out_if.source                     out_ch,
    input  logic                          cfg_we,
    input  logic [lat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lat_pkg::DIM_W-1:0]     cfg_data
);

    lat_pkg::lat_cmd_t  cmd;
    lat_pkg::lat_stat_t stat;

    lat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lat_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_mode         (in_ch.mode),
        .in_column       (in_ch.column),
        .in_row          (in_ch.row),
        .cmd             (cmd),
        .stat            (stat),
        .out_ready       (out_ch.ready),
        .out_valid       (out_ch.valid),
        .out_cell_alive  (out_ch.cell_alive),
        .out_coord_error (out_ch.coord_error),
        .out_done_mode   (out_ch.done_mode)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("ready stayed high after an item was taken");

    a_err_dead: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.coord_error |-> !out_ch.cell_alive)
        else $error("out-of-range item reports a live cell");

    a_gen_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.done_mode == lat_pkg::MODE_GENERATE
        |-> !out_ch.coord_error && !out_ch.cell_alive)
        else $error("generation result fields not zero");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_ch.valid || out_ch.ready)
        else $error("result register overwritten before it was taken");

endmodule

### hdl/lat_datapath.sv
module lat_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lat_pkg::DIM_W-1:0]     cfg_data,
    input  logic [lat_pkg::MODE_W-1:0]    in_mode,
    input  logic [lat_pkg::COL_W-1:0]     in_column,
    input  logic [lat_pkg::ROW_W-1:0]     in_row,
    input  lat_pkg::lat_cmd_t             cmd,
    output lat_pkg::lat_stat_t            stat,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_cell_alive,
    output logic                          out_coord_error,
    output logic [lat_pkg::MODE_W-1:0]    out_done_mode
);

    logic [lat_pkg::DIM_W-1:0]   width_reg, height_reg;
    logic [lat_pkg::DIM_W-1:0]   w, h;
    logic [lat_pkg::COL_W-1:0]   x_reg, x_next;
    logic [lat_pkg::ROW_W-1:0]   y_reg, y_next;
    logic [lat_pkg::STEP_W-1:0]  step_reg;
    logic [lat_pkg::MODE_W-1:0]  mode_reg;
    logic                        err_reg;
    logic                        tgt_reg;
    logic                        res_reg;
    logic                        out_valid_reg;
    logic                        out_alive_reg;
    logic                        out_err_reg;
    logic [lat_pkg::MODE_W-1:0]  out_mode_reg;

    logic [lat_pkg::ENTRY_W-1:0] cell_mem [lat_pkg::CELLS];
    logic [lat_pkg::ENTRY_W-1:0] snap_mem [lat_pkg::CELLS];
    logic [lat_pkg::ENTRY_W-1:0] cell_rdata_reg, snap_rdata_reg;
    logic [lat_pkg::ENTRY_W-1:0] cell_wdata;
    logic                        cell_we;
    logic [lat_pkg::ADDR_W-1:0]  center_addr, nbr_addr, cell_addr;
    logic [lat_pkg::COL_W-1:0]   xm, xp, nx;
    logic [lat_pkg::ROW_W-1:0]   ym, yp, ny;
    logic                        x_end, y_end, in_err;
    logic [lat_pkg::COUNT_W-1:0] snap_count;

    assign w = lat_pkg::clamp_dim(width_reg, lat_pkg::DIM_W'(lat_pkg::MAX_WIDTH));
    assign h = lat_pkg::clamp_dim(height_reg, lat_pkg::DIM_W'(lat_pkg::MAX_HEIGHT));

    assign x_end = ({1'b0, x_reg} == w - 1'b1);
    assign y_end = ({1'b0, y_reg} == h - 1'b1);

    // torus neighbours of the current cell
    assign xm = (x_reg == '0) ? lat_pkg::COL_W'(w - 1'b1) : x_reg - 1'b1;
    assign xp = x_end ? '0 : x_reg + 1'b1;
    assign ym = (y_reg == '0) ? lat_pkg::ROW_W'(h - 1'b1) : y_reg - 1'b1;
    assign yp = y_end ? '0 : y_reg + 1'b1;

    always_comb
    begin
        case (step_reg)
            4'd1:    begin nx = xm;    ny = ym;    end
            4'd2:    begin nx = x_reg; ny = ym;    end
            4'd3:    begin nx = xp;    ny = ym;    end
            4'd4:    begin nx = xm;    ny = y_reg; end
            4'd5:    begin nx = xp;    ny = y_reg; end
            4'd6:    begin nx = xm;    ny = yp;    end
            4'd7:    begin nx = x_reg; ny = yp;    end
            4'd8:    begin nx = xp;    ny = yp;    end
            default: begin nx = x_reg; ny = y_reg; end
        endcase
    end

    // row * MAX_WIDTH + column, MAX_WIDTH being a power of two
    assign center_addr = {y_reg, x_reg};
    assign nbr_addr    = {ny, nx};
    assign cell_addr   = cmd.use_step ? nbr_addr : center_addr;

    always_comb
    begin
        cell_we = cmd.cell_wr_put | cmd.cell_wr_clear;
        if (cmd.cell_wr_clear)
            cell_wdata = '0;
        else if (step_reg == '0)
            cell_wdata = tgt_reg ? (cell_rdata_reg | lat_pkg::ALIVE_BIT)
                                 : (cell_rdata_reg & ~lat_pkg::ALIVE_BIT);
        else
            cell_wdata = tgt_reg ? (cell_rdata_reg + lat_pkg::COUNT_ONE)
                                 : (cell_rdata_reg - lat_pkg::COUNT_ONE);
    end

    always_ff @(posedge clk)
    begin
        if (cell_we)
            cell_mem[cell_addr] <= cell_wdata;
        cell_rdata_reg <= cell_mem[cell_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.snap_wr)
            snap_mem[center_addr] <= cell_rdata_reg;
        snap_rdata_reg <= snap_mem[center_addr];
    end

    assign in_err = ({1'b0, in_column} >= w) || ({1'b0, in_row} >= h);

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        if (cmd.load_item)
        begin
            x_next = in_column;
            y_next = in_row;
        end
        else if (cmd.pos_clr)
        begin
            x_next = '0;
            y_next = '0;
        end
        else if (cmd.clear_advance)
            {y_next, x_next} = {y_reg, x_reg} + 1'b1;
        else if (cmd.advance)
        begin
            if (x_end)
            begin
                x_next = '0;
                y_next = y_reg + 1'b1;
            end
            else
                x_next = x_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= lat_pkg::DIM_W'(lat_pkg::MAX_WIDTH);
            height_reg    <= lat_pkg::DIM_W'(lat_pkg::MAX_HEIGHT);
            x_reg         <= '0;
            y_reg         <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == lat_pkg::REG_GRID_WIDTH)
                width_reg <= cfg_data;
            if (cfg_we && cfg_index == lat_pkg::REG_GRID_HEIGHT)
                height_reg <= cfg_data;
            x_reg <= x_next;
            y_reg <= y_next;
            if (cmd.step_clr)
                step_reg <= '0;
            else if (cmd.step_inc)
                step_reg <= step_reg + 1'b1;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg <= in_mode;
            err_reg  <= in_err && (in_mode != lat_pkg::MODE_GENERATE);
            tgt_reg  <= (in_mode == lat_pkg::MODE_SET_ALIVE);
            res_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.tgt_from_scan)
                tgt_reg <= ~snap_rdata_reg[0];
            if (cmd.res_from_now)
                res_reg <= cell_rdata_reg[0];
            else if (cmd.res_from_tgt)
                res_reg <= tgt_reg;
        end
        if (cmd.out_load)
        begin
            out_alive_reg <= res_reg;
            out_err_reg   <= err_reg;
            out_mode_reg  <= mode_reg;
        end
    end

    assign snap_count = snap_rdata_reg[lat_pkg::COUNT_W:1];

    always_comb
    begin
        stat.now_alive  = cell_rdata_reg[0];
        stat.tgt_alive  = tgt_reg;
        stat.mode_read  = (mode_reg == lat_pkg::MODE_READ);
        stat.mode_gen   = (mode_reg == lat_pkg::MODE_GENERATE);
        stat.coord_err  = err_reg;
        stat.step_last  = (step_reg == lat_pkg::STEP_LAST);
        stat.scan_last  = x_end && y_end;
        stat.clear_last = &{y_reg, x_reg};
        if (snap_rdata_reg[0])
            stat.gen_change = (snap_count != lat_pkg::COUNT_SURVIVE)
                           && (snap_count != lat_pkg::COUNT_BIRTH);
        else
            stat.gen_change = (snap_count == lat_pkg::COUNT_BIRTH);
        stat.out_busy   = out_valid_reg && !out_ready;
    end

    assign out_valid       = out_valid_reg;
    assign out_cell_alive  = out_alive_reg;
    assign out_coord_error = out_err_reg;
    assign out_done_mode   = out_mode_reg;

endmodule

### hdl/lat_ctrl.sv
module lat_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lat_pkg::lat_stat_t stat,
    output lat_pkg::lat_cmd_t  cmd
);

    lat_pkg::lat_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lat_pkg::ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            lat_pkg::ST_CLEAR:
            begin
                cmd.cell_wr_clear = 1'b1;
                cmd.clear_advance = 1'b1;
                if (stat.clear_last)
                    state_next = lat_pkg::ST_IDLE;
            end
            lat_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = lat_pkg::ST_DECODE;
                end
            end
            lat_pkg::ST_DECODE:
            begin
                if (stat.mode_gen)
                begin
                    cmd.pos_clr = 1'b1;
                    state_next  = lat_pkg::ST_COPY_RD;
                end
                else if (stat.coord_err)
                    state_next = lat_pkg::ST_OUT;
                else
                    state_next = lat_pkg::ST_CHECK_RD;
            end
            lat_pkg::ST_CHECK_RD:
                state_next = lat_pkg::ST_CHECK;
            lat_pkg::ST_CHECK:
            begin
                // a set to the state already held changes nothing
                if (stat.mode_read || stat.now_alive == stat.tgt_alive)
                begin
                    cmd.res_from_now = 1'b1;
                    state_next       = lat_pkg::ST_OUT;
                end
                else
                begin
                    cmd.res_from_tgt = 1'b1;
                    cmd.step_clr     = 1'b1;
                    state_next       = lat_pkg::ST_PUT_RD;
                end
            end
            lat_pkg::ST_PUT_RD:
            begin
                cmd.use_step = 1'b1;
                state_next   = lat_pkg::ST_PUT_WR;
            end
            lat_pkg::ST_PUT_WR:
            begin
                cmd.use_step    = 1'b1;
                cmd.cell_wr_put = 1'b1;
                cmd.step_inc    = 1'b1;
                if (!stat.step_last)
                    state_next = lat_pkg::ST_PUT_RD;
                else if (!stat.mode_gen)
                    state_next = lat_pkg::ST_OUT;
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = stat.scan_last ? lat_pkg::ST_OUT : lat_pkg::ST_SCAN_RD;
                end
            end
            lat_pkg::ST_COPY_RD:
                state_next = lat_pkg::ST_COPY_WR;
            lat_pkg::ST_COPY_WR:
            begin
                cmd.snap_wr = 1'b1;
                if (stat.scan_last)
                begin
                    cmd.pos_clr = 1'b1;
                    state_next  = lat_pkg::ST_SCAN_RD;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = lat_pkg::ST_COPY_RD;
                end
            end
            lat_pkg::ST_SCAN_RD:
                state_next = lat_pkg::ST_SCAN_EV;
            lat_pkg::ST_SCAN_EV:
            begin
                if (stat.gen_change)
                begin
                    cmd.tgt_from_scan = 1'b1;
                    cmd.step_clr      = 1'b1;
                    state_next        = lat_pkg::ST_PUT_RD;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = stat.scan_last ? lat_pkg::ST_OUT : lat_pkg::ST_SCAN_RD;
                end
            end
            lat_pkg::ST_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = lat_pkg::ST_IDLE;
                end
            end
            default:
                state_next = lat_pkg::ST_IDLE;
        endcase
    end

endmodule

### tb/tb_life_automaton_torus_engine_top.sv
module tb_life_automaton_torus_engine_top;

    typedef struct {
        logic [lat_pkg::MODE_W-1:0] mode;
        logic [lat_pkg::COL_W-1:0]  column;
        logic [lat_pkg::ROW_W-1:0]  row;
    } life_cmd_t;

    typedef struct {
        logic                       cell_alive;
        logic                       coord_error;
        logic [lat_pkg::MODE_W-1:0] done_mode;
    } life_res_t;

    localparam int WATCHDOG_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [lat_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [lat_pkg::DIM_W-1:0]     cfg_data;

    lat_in_if  in_ch();
    lat_out_if out_ch();

    life_automaton_torus_engine_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // golden copy of the grid
    logic [lat_pkg::ENTRY_W-1:0] grid_mem[lat_pkg::CELLS];
    logic [lat_pkg::ENTRY_W-1:0] snap_mem[lat_pkg::CELLS];
    logic [lat_pkg::DIM_W-1:0]   width_reg;
    logic [lat_pkg::DIM_W-1:0]   height_reg;

    life_cmd_t pending_q[$];
    life_res_t expected_q[$];
    int  err_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_send;
    int  quiet_cycles;

    always #5 clk = ~clk;

    function automatic int eff_dim(logic [lat_pkg::DIM_W-1:0] v, int hi);
        int r;
        r = v;
        if (r < 3)
            r = 3;
        else if (r > hi)
            r = hi;
        return r;
    endfunction

    function automatic void update_cell(int x, int y, bit alive, int w, int h);
        int xs[3];
        int ys[3];
        int idx;
        idx = y * lat_pkg::MAX_WIDTH + x;
        if (grid_mem[idx][0] == alive)
            return;
        grid_mem[idx][0] = alive;
        xs[0] = (x == 0) ? w - 1 : x - 1;
        xs[1] = x;
        xs[2] = (x + 1 >= w) ? 0 : x + 1;
        ys[0] = (y == 0) ? h - 1 : y - 1;
        ys[1] = y;
        ys[2] = (y + 1 >= h) ? 0 : y + 1;
        for (int j = 0; j < 3; j++)
            for (int i = 0; i < 3; i++)
                if (!(i == 1 && j == 1)) begin
                    idx = ys[j] * lat_pkg::MAX_WIDTH + xs[i];
                    if (alive)
                        grid_mem[idx] = grid_mem[idx] + lat_pkg::COUNT_ONE;
                    else
                        grid_mem[idx] = grid_mem[idx] - lat_pkg::COUNT_ONE;
                end
    endfunction

    function automatic void step_generation(int w, int h);
        logic [lat_pkg::ENTRY_W-1:0] s;
        logic [lat_pkg::COUNT_W-1:0] n;
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                snap_mem[y * lat_pkg::MAX_WIDTH + x] = grid_mem[y * lat_pkg::MAX_WIDTH + x];
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++) begin
                s = snap_mem[y * lat_pkg::MAX_WIDTH + x];
                n = s[lat_pkg::ENTRY_W-1:1];
                if (s != '0) begin
                    if (s[0]) begin
                        if (n != lat_pkg::COUNT_SURVIVE && n != lat_pkg::COUNT_BIRTH)
                            update_cell(x, y, 1'b0, w, h);
                    end
                    else if (n == lat_pkg::COUNT_BIRTH)
                        update_cell(x, y, 1'b1, w, h);
                end
            end
    endfunction

    function automatic life_res_t predict_item(life_cmd_t c);
        life_res_t r;
        int w;
        int h;
        w = eff_dim(width_reg, lat_pkg::MAX_WIDTH);
        h = eff_dim(height_reg, lat_pkg::MAX_HEIGHT);
        r.cell_alive  = 1'b0;
        r.coord_error = 1'b0;
        r.done_mode   = c.mode;
        if (c.mode == lat_pkg::MODE_GENERATE)
            step_generation(w, h);
        else if (c.column >= w || c.row >= h)
            r.coord_error = 1'b1;
        else begin
            if (c.mode == lat_pkg::MODE_SET_ALIVE)
                update_cell(c.column, c.row, 1'b1, w, h);
            else if (c.mode == lat_pkg::MODE_SET_DEAD)
                update_cell(c.column, c.row, 1'b0, w, h);
            r.cell_alive = grid_mem[c.row * lat_pkg::MAX_WIDTH + c.column][0];
        end
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                expected_q.push_back(predict_item('{in_ch.mode, in_ch.column, in_ch.row}));
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_q.size() > 0 && !hold_send &&
                    $urandom_range(0, 99) >= send_idle_pct)
                begin
                    life_cmd_t c;
                    c = pending_q.pop_front();
                    in_ch.valid  <= 1'b1;
                    in_ch.mode   <= c.mode;
                    in_ch.column <= c.column;
                    in_ch.row    <= c.row;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result with no item pending: mode %0d", out_ch.done_mode);
                    err_count++;
                end
                else
                begin
                    life_res_t e;
                    e = expected_q.pop_front();
                    if (out_ch.cell_alive !== e.cell_alive)
                    begin
                        $error("cell_alive: expected %0d, got %0d", e.cell_alive,
                               out_ch.cell_alive);
                        err_count++;
                    end
                    if (out_ch.coord_error !== e.coord_error)
                    begin
                        $error("coord_error: expected %0d, got %0d", e.coord_error,
                               out_ch.coord_error);
                        err_count++;
                    end
                    if (out_ch.done_mode !== e.done_mode)
                    begin
                        $error("done_mode: expected %0d, got %0d", e.done_mode,
                               out_ch.done_mode);
                        err_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[life_automaton_torus_engine_top] ERROR");
            $finish;
        end
    end

    task automatic push_cmd(logic [lat_pkg::MODE_W-1:0] m, int x, int y);
        pending_q.push_back('{m, lat_pkg::COL_W'(x), lat_pkg::ROW_W'(y)});
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || in_ch.valid || expected_q.size() > 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [lat_pkg::CFG_IDX_W-1:0] idx,
                             logic [lat_pkg::DIM_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == lat_pkg::REG_GRID_WIDTH)
            width_reg = val;
        else
            height_reg = val;
    endtask

    // mostly build-and-evolve patterns inside the grid; some noise out of range
    task automatic push_random(int count);
        int w;
        int h;
        int p;
        w = eff_dim(width_reg, lat_pkg::MAX_WIDTH);
        h = eff_dim(height_reg, lat_pkg::MAX_HEIGHT);
        for (int k = 0; k < count; k++)
        begin
            p = $urandom_range(0, 99);
            if (p < 10)
                push_cmd(lat_pkg::MODE_W'($urandom_range(0, 3)),
                         $urandom_range(0, 63), $urandom_range(0, 63));
            else if (p < 45)
                push_cmd(lat_pkg::MODE_SET_ALIVE, $urandom_range(0, w - 1),
                         $urandom_range(0, h - 1));
            else if (p < 58)
                push_cmd(lat_pkg::MODE_SET_DEAD, $urandom_range(0, w - 1),
                         $urandom_range(0, h - 1));
            else if (p < 80)
                push_cmd(lat_pkg::MODE_READ, $urandom_range(0, w - 1),
                         $urandom_range(0, h - 1));
            else
                push_cmd(lat_pkg::MODE_GENERATE, $urandom_range(0, 63),
                         $urandom_range(0, 63));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = lat_pkg::REG_GRID_WIDTH;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = lat_pkg::MODE_READ;
        in_ch.column = '0;
        in_ch.row = '0;
        out_ch.ready = 1'b0;
        err_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_send = 1'b0;
        quiet_cycles = 0;
        width_reg = lat_pkg::DIM_W'(64);
        height_reg = lat_pkg::DIM_W'(64);
        for (int i = 0; i < lat_pkg::CELLS; i++)
        begin
            grid_mem[i] = '0;
            snap_mem[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // full grid: blinker across the wrapping corner, no-op sets, two generations
        push_cmd(lat_pkg::MODE_READ, 0, 0);
        push_cmd(lat_pkg::MODE_SET_ALIVE, 0, 0);
        push_cmd(lat_pkg::MODE_SET_ALIVE, 1, 0);
        push_cmd(lat_pkg::MODE_SET_ALIVE, 63, 0);
        push_cmd(lat_pkg::MODE_SET_ALIVE, 0, 0);
        push_cmd(lat_pkg::MODE_SET_DEAD, 5, 5);
        push_cmd(lat_pkg::MODE_READ, 0, 0);
        push_cmd(lat_pkg::MODE_GENERATE, 63, 63);
        push_cmd(lat_pkg::MODE_READ, 0, 63);
        push_cmd(lat_pkg::MODE_READ, 0, 1);
        push_cmd(lat_pkg::MODE_READ, 1, 0);
        push_cmd(lat_pkg::MODE_READ, 63, 0);
        push_cmd(lat_pkg::MODE_SET_DEAD, 0, 0);
        push_cmd(lat_pkg::MODE_SET_ALIVE, 63, 63);
        push_cmd(lat_pkg::MODE_READ, 63, 63);
        push_cmd(lat_pkg::MODE_GENERATE, 0, 0);
        push_cmd(lat_pkg::MODE_READ, 63, 63);
        drain();

        // smallest width, tallest height (0 and 127 clamp)
        write_reg(lat_pkg::REG_GRID_WIDTH, lat_pkg::DIM_W'(0));
        write_reg(lat_pkg::REG_GRID_HEIGHT, lat_pkg::DIM_W'(127));
        send_idle_pct = 80;
        push_cmd(lat_pkg::MODE_READ, 3, 0);
        push_cmd(lat_pkg::MODE_SET_ALIVE, 63, 63);
        push_cmd(lat_pkg::MODE_SET_DEAD, 0, 63);
        push_cmd(lat_pkg::MODE_SET_ALIVE, 0, 2);
        push_cmd(lat_pkg::MODE_SET_ALIVE, 1, 2);
        push_cmd(lat_pkg::MODE_SET_ALIVE, 2, 2);
        push_cmd(lat_pkg::MODE_GENERATE, 0, 0);
        push_cmd(lat_pkg::MODE_READ, 1, 1);
        push_random(20);
        drain();

        write_reg(lat_pkg::REG_GRID_WIDTH, lat_pkg::DIM_W'(10));
        write_reg(lat_pkg::REG_GRID_HEIGHT, lat_pkg::DIM_W'(8));
        send_idle_pct = 0;
        recv_stall_pct = 80;
        push_random(28);
        drain();

        // hold the sender until everything has drained, then resume
        hold_send = 1'b1;
        push_random(6);
        while (expected_q.size() > 0 || in_ch.valid)
            @(posedge clk);
        hold_send = 1'b0;
        drain();

        // widest (65 clamps) and shortest (2 clamps)
        write_reg(lat_pkg::REG_GRID_WIDTH, lat_pkg::DIM_W'(65));
        write_reg(lat_pkg::REG_GRID_HEIGHT, lat_pkg::DIM_W'(2));
        send_idle_pct = 6;
        recv_stall_pct = 6;
        push_random(28);
        drain();

        write_reg(lat_pkg::REG_GRID_WIDTH, lat_pkg::DIM_W'(16));
        write_reg(lat_pkg::REG_GRID_HEIGHT, lat_pkg::DIM_W'(3));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        push_random(28);
        drain();

        repeat (50) @(posedge clk);
        if (err_count == 0)
            $display("[life_automaton_torus_engine_top] OK");
        else
            $display("[life_automaton_torus_engine_top] ERROR");
        $finish;
    end

endmodule
